/* src/rbv_pkg.sv */
// Shared constants and side-data types for the rotation-between-vectors pipeline.
package rbv_pkg;

    localparam int unsigned COMP_W  = 16;   // input component and matrix entry width
    localparam int unsigned RAD_W   = 62;   // normalized squared length
    localparam int unsigned ROOT_W  = 31;   // square root of the normalized length
    localparam int unsigned UQ_W    = 16;   // unit component quotient width
    localparam int unsigned DEN_W   = 31;   // 1 + cos, Q28, positive
    localparam int unsigned SQ_W    = 33;   // quotient width of the squared term
    localparam int unsigned V_W     = 31;   // cross product component, Q28
    localparam int unsigned MIN_D_W = 15;

    localparam logic signed [COMP_W-1:0] ONE_Q14   = 16'sd16384;
    localparam logic signed [35:0]       ONE_Q28   = 36'sd268435456;
    localparam logic [MIN_D_W-1:0]       MIN_D_RST = 15'd16;

    // Register select on paddr[2].
    localparam logic REG_MIN_DEN = 1'b0;

    typedef struct packed {
        logic [1:0][2:0][15:0] mag;
        logic [1:0][2:0]       neg;
        logic [1:0]            zero;
        logic [1:0][5:0]       shift;
    } t_norm_side;

    typedef struct packed {
        logic [5:0] neg;
        logic [1:0] zero;
    } t_unit_side;

    typedef struct packed {
        logic [2:0][V_W-1:0] v;
        logic [5:0]          neg;
        logic                deg;
    } t_rot_side;

endpackage

/* src/rbv_isqrt.sv */
// Pipelined integer square root, one result bit per stage, several lanes in lockstep.
module rbv_isqrt #(
    parameter int LANES = 2,
    parameter int W     = 62,
    parameter int SW    = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [LANES-1:0][W-1:0]       i_rad,
    input  logic [SW-1:0]                 i_side,
    output logic                          o_valid,
    output logic [LANES-1:0][W/2-1:0]     o_root,
    output logic [SW-1:0]                 o_side
);

    localparam int STG = W / 2;
    localparam int RW  = STG + 2;

    logic [STG-1:0]              r_vld;
    logic [LANES-1:0][W-1:0]     r_rad  [STG];
    logic [LANES-1:0][STG-1:0]   r_root [STG];
    logic [LANES-1:0][RW-1:0]    r_rem  [STG];
    logic [SW-1:0]               r_side [STG];

    logic [LANES-1:0][W-1:0]     n_rad  [STG];
    logic [LANES-1:0][STG-1:0]   n_root [STG];
    logic [LANES-1:0][RW-1:0]    n_rem  [STG];
    logic [SW-1:0]               n_side [STG];

    always_comb begin
        logic [W-1:0]    rad;
        logic [STG-1:0]  rt;
        logic [RW-1:0]   rm;
        logic [RW+1:0]   sh;
        logic [RW+1:0]   trial;
        for (int s = 0; s < STG; s++) begin
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    rad = i_rad[l];
                    rt  = '0;
                    rm  = '0;
                end else begin
                    rad = r_rad[s-1][l];
                    rt  = r_root[s-1][l];
                    rm  = r_rem[s-1][l];
                end
                // bring down the next two radicand bits
                sh    = {rm, rad[2*(STG-1-s) +: 2]};
                trial = (RW+2)'({rt, 2'b01});
                if (sh >= trial) begin
                    rm = RW'(sh - trial);
                    rt = {rt[STG-2:0], 1'b1};
                end else begin
                    rm = RW'(sh);
                    rt = {rt[STG-2:0], 1'b0};
                end
                n_rad[s][l]  = rad;
                n_root[s][l] = rt;
                n_rem[s][l]  = rm;
            end
            n_side[s] = (s == 0) ? i_side : r_side[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < STG; s++) begin
                r_rad[s]  <= n_rad[s];
                r_root[s] <= n_root[s];
                r_rem[s]  <= n_rem[s];
                r_side[s] <= n_side[s];
            end
        end
    end

    assign o_valid = r_vld[STG-1];
    assign o_root  = r_root[STG-1];
    assign o_side  = r_side[STG-1];

endmodule

/* src/rbv_div.sv */
// Pipelined restoring divider, one quotient bit per stage, saturating on overflow.
module rbv_div #(
    parameter int LANES = 6,
    parameter int DW    = 31,
    parameter int QW    = 16,
    parameter int SW    = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [LANES-1:0][DW+QW-1:0]   i_num,
    input  logic [LANES-1:0][DW-1:0]      i_den,
    input  logic [SW-1:0]                 i_side,
    output logic                          o_valid,
    output logic [LANES-1:0][QW-1:0]      o_quo,
    output logic [SW-1:0]                 o_side
);

    localparam int NW = DW + QW;

    logic [QW-1:0]               r_vld;
    logic [LANES-1:0][NW-1:0]    r_rem  [QW];
    logic [LANES-1:0][DW-1:0]    r_den  [QW];
    logic [LANES-1:0][QW-1:0]    r_quo  [QW];
    logic [LANES-1:0]            r_sat  [QW];
    logic [SW-1:0]               r_side [QW];

    logic [LANES-1:0][NW-1:0]    n_rem  [QW];
    logic [LANES-1:0][DW-1:0]    n_den  [QW];
    logic [LANES-1:0][QW-1:0]    n_quo  [QW];
    logic [LANES-1:0]            n_sat  [QW];
    logic [SW-1:0]               n_side [QW];

    always_comb begin
        logic [NW-1:0] rem;
        logic [NW-1:0] trial;
        logic [DW-1:0] den;
        logic [QW-1:0] quo;
        logic          sat;
        for (int s = 0; s < QW; s++) begin
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    rem = i_num[l];
                    den = i_den[l];
                    quo = '0;
                    // quotient would not fit: clamp at the end
                    sat = (i_num[l][NW-1:QW] >= i_den[l]);
                end else begin
                    rem = r_rem[s-1][l];
                    den = r_den[s-1][l];
                    quo = r_quo[s-1][l];
                    sat = r_sat[s-1][l];
                end
                trial = NW'(den) << (QW - 1 - s);
                if (rem >= trial) begin
                    rem              = rem - trial;
                    quo[QW - 1 - s]  = 1'b1;
                end
                n_rem[s][l] = rem;
                n_den[s][l] = den;
                n_quo[s][l] = quo;
                n_sat[s][l] = sat;
            end
            n_side[s] = (s == 0) ? i_side : r_side[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < QW; s++) begin
                r_rem[s]  <= n_rem[s];
                r_den[s]  <= n_den[s];
                r_quo[s]  <= n_quo[s];
                r_sat[s]  <= n_sat[s];
                r_side[s] <= n_side[s];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_sat[QW-1][l] ? '1 : r_quo[QW-1][l];
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

/* src/rotation_between_vectors.sv */
// Top level: rotation matrix that turns one 3-D direction onto another.
//
// Slave stream: one transfer carries a vector pair, six signed Q8.8
// components (from_x..from_z, to_x..to_z). Master stream: one transfer per
// pair with the nine Q2.14 matrix entries in tdata and the degenerate flag
// in tuser. A zero input or 1 + cos below min_denominator sets the flag and
// yields the identity.
// The datapath is a single pipeline made up of a 31-stage square root, a
// 16-stage divider for the unit vectors, a 33-stage divider for the squared
// term and 15 arithmetic stages. A new pair is taken in every cycle while
// no result waits on a stalled receiver, so throughput is one pair per cycle.
// When the receiver holds tready low with a result waiting, the whole
// pipeline freezes and o_s_tready drops; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and sets
// min_denominator to 16. The APB register min_denominator (address 0) may
// only be written while no pair is in flight.
module rotation_between_vectors (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [95:0]   i_s_tdata,    // from_x, from_y, from_z, to_x, to_y, to_z
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [143:0]  o_m_tdata,    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic          o_m_tuser,    // degenerate
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int CW = rbv_pkg::COMP_W;
    localparam int VW = rbv_pkg::V_W;
    localparam int DN = rbv_pkg::DEN_W;

    logic en;

    // ---------------- configuration ----------------
    logic [rbv_pkg::MIN_D_W-1:0] r_min_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_den <= rbv_pkg::MIN_D_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == rbv_pkg::REG_MIN_DEN) begin
            r_min_den <= pwdata[rbv_pkg::MIN_D_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rbv_pkg::REG_MIN_DEN) ? 32'(r_min_den) : 32'd0;

    // ---------------- stages 1..4: squared length and scaling ----------------
    logic                 r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld;
    logic signed [CW-1:0] r_p1_w  [6];
    logic [30:0]          r_p1_sq [6];
    logic signed [CW-1:0] r_p2_w  [6];
    logic [31:0]          r_p2_n2 [2];
    logic signed [CW-1:0] r_p3_w  [6];
    logic [31:0]          r_p3_n2 [2];
    logic [4:0]           r_p3_k  [2];
    logic [1:0][rbv_pkg::RAD_W-1:0] r_p4_rad;
    rbv_pkg::t_norm_side  r_p4_side;

    logic [4:0] n_k [2];

    always_comb begin
        logic [5:0] len;
        for (int v = 0; v < 2; v++) begin
            len = '0;
            for (int b = 0; b < 32; b++) begin
                if (r_p2_n2[v][b]) len = 6'(b + 1);
            end
            // largest shift that keeps n2 * 4^k below 2^62
            n_k[v] = 5'(((6'd60 - len) >> 1) + 6'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                r_p1_w[i]  <= $signed(i_s_tdata[CW*i +: CW]);
                r_p1_sq[i] <= 31'($signed(i_s_tdata[CW*i +: CW]) * $signed(i_s_tdata[CW*i +: CW]));
                r_p2_w[i]  <= r_p1_w[i];
                r_p3_w[i]  <= r_p2_w[i];
            end
            for (int v = 0; v < 2; v++) begin
                r_p2_n2[v] <= 32'(r_p1_sq[3*v]) + 32'(r_p1_sq[3*v+1]) + 32'(r_p1_sq[3*v+2]);
                r_p3_n2[v] <= r_p2_n2[v];
                r_p3_k[v]  <= n_k[v];
                r_p4_rad[v] <= rbv_pkg::RAD_W'(r_p3_n2[v]) << {r_p3_k[v], 1'b0};
                r_p4_side.zero[v]  <= (r_p3_n2[v] == 32'd0);
                r_p4_side.shift[v] <= 6'(r_p3_k[v]) + 6'd14;
                for (int i = 0; i < 3; i++) begin
                    r_p4_side.neg[v][i] <= r_p3_w[3*v+i][CW-1];
                    r_p4_side.mag[v][i] <= r_p3_w[3*v+i][CW-1] ? 16'(-r_p3_w[3*v+i])
                                                                : 16'(r_p3_w[3*v+i]);
                end
            end
        end
    end

    // ---------------- square root ----------------
    logic                               sq_vld;
    logic [1:0][rbv_pkg::ROOT_W-1:0]    sq_root;
    rbv_pkg::t_norm_side                sq_side;

    rbv_isqrt #(
        .LANES (2),
        .W     (rbv_pkg::RAD_W),
        .SW    ($bits(rbv_pkg::t_norm_side))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p4_vld),
        .i_rad   (r_p4_rad),
        .i_side  (r_p4_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ---------------- stage 5: unit component numerators ----------------
    localparam int UNW = rbv_pkg::ROOT_W + rbv_pkg::UQ_W;

    logic                           r_p5_vld;
    logic [5:0][UNW-1:0]            r_p5_num;
    logic [5:0][rbv_pkg::ROOT_W-1:0] r_p5_den;
    rbv_pkg::t_unit_side            r_p5_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int v = 0; v < 2; v++) begin
                for (int i = 0; i < 3; i++) begin
                    r_p5_num[3*v+i] <= UNW'((64'(sq_side.mag[v][i]) << sq_side.shift[v])
                                           + 64'(sq_root[v] >> 1));
                    r_p5_den[3*v+i] <= sq_root[v];
                    r_p5_side.neg[3*v+i] <= sq_side.neg[v][i];
                end
            end
            r_p5_side.zero <= sq_side.zero;
        end
    end

    logic                          ud_vld;
    logic [5:0][rbv_pkg::UQ_W-1:0] ud_quo;
    rbv_pkg::t_unit_side           ud_side;

    rbv_div #(
        .LANES (6),
        .DW    (rbv_pkg::ROOT_W),
        .QW    (rbv_pkg::UQ_W),
        .SW    ($bits(rbv_pkg::t_unit_side))
    ) u_div_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p5_vld),
        .i_num   (r_p5_num),
        .i_den   (r_p5_den),
        .i_side  (r_p5_side),
        .o_valid (ud_vld),
        .o_quo   (ud_quo),
        .o_side  (ud_side)
    );

    // ---------------- stages 6..12: products and squared term ----------------
    logic                 r_p6_vld, r_p7_vld, r_p8_vld, r_p9_vld, r_p10_vld, r_p11_vld, r_p12_vld;
    logic signed [CW-1:0] r_p6_u [6];
    logic [1:0]           r_p6_zero, r_p7_zero;
    logic signed [31:0]   r_p7_p [9];
    logic signed [VW-1:0] r_p8_v [3], r_p9_v [3], r_p10_v [3], r_p11_v [3];
    logic [DN-1:0]        r_p8_d, r_p9_d, r_p10_d, r_p11_d, r_p12_d;
    logic                 r_p8_deg, r_p9_deg, r_p10_deg, r_p11_deg;
    logic signed [61:0]   r_p9_pp [6], r_p10_pp [6];
    logic signed [63:0]   r_p10_vv;
    logic signed [63:0]   r_p11_s [6];
    logic [5:0][63:0]     r_p12_num;
    rbv_pkg::t_rot_side   r_p12_side;

    logic [rbv_pkg::UQ_W-1:0] n_umag [6];
    logic signed [33:0]       n_c, n_d, n_thr;
    logic                     n_deg;
    logic [63:0]              n_smag [6];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            n_umag[i] = (ud_quo[i] > 16'(rbv_pkg::ONE_Q14)) ? 16'(rbv_pkg::ONE_Q14) : ud_quo[i];
        end
        n_c   = 34'(r_p7_p[6]) + 34'(r_p7_p[7]) + 34'(r_p7_p[8]);
        n_d   = 34'sd268435456 + n_c;
        n_thr = $signed({5'b0, r_min_den, 14'b0});
        n_deg = r_p7_zero[0] || r_p7_zero[1] || (n_d <= 34'sd0) || (n_d < n_thr);
        for (int i = 0; i < 6; i++) begin
            n_smag[i] = r_p11_s[i][63] ? 64'(-r_p11_s[i]) : 64'(r_p11_s[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                r_p6_u[i] <= ud_side.neg[i] ? -$signed(n_umag[i]) : $signed(n_umag[i]);
            end
            r_p6_zero <= ud_side.zero;

            // a = u[0..2], b = u[3..5]
            r_p7_p[0] <= r_p6_u[1] * r_p6_u[5];
            r_p7_p[1] <= r_p6_u[2] * r_p6_u[4];
            r_p7_p[2] <= r_p6_u[2] * r_p6_u[3];
            r_p7_p[3] <= r_p6_u[0] * r_p6_u[5];
            r_p7_p[4] <= r_p6_u[0] * r_p6_u[4];
            r_p7_p[5] <= r_p6_u[1] * r_p6_u[3];
            r_p7_p[6] <= r_p6_u[0] * r_p6_u[3];
            r_p7_p[7] <= r_p6_u[1] * r_p6_u[4];
            r_p7_p[8] <= r_p6_u[2] * r_p6_u[5];
            r_p7_zero <= r_p6_zero;

            r_p8_v[0] <= VW'(r_p7_p[0] - r_p7_p[1]);
            r_p8_v[1] <= VW'(r_p7_p[2] - r_p7_p[3]);
            r_p8_v[2] <= VW'(r_p7_p[4] - r_p7_p[5]);
            r_p8_deg  <= n_deg;
            // keep the divider harmless when the result is forced to identity
            r_p8_d    <= n_deg ? DN'(1) : n_d[DN-1:0];

            r_p9_pp[0] <= r_p8_v[0] * r_p8_v[0];
            r_p9_pp[1] <= r_p8_v[1] * r_p8_v[1];
            r_p9_pp[2] <= r_p8_v[2] * r_p8_v[2];
            r_p9_pp[3] <= r_p8_v[0] * r_p8_v[1];
            r_p9_pp[4] <= r_p8_v[0] * r_p8_v[2];
            r_p9_pp[5] <= r_p8_v[1] * r_p8_v[2];
            r_p9_v     <= r_p8_v;
            r_p9_d     <= r_p8_d;
            r_p9_deg   <= r_p8_deg;

            r_p10_vv  <= 64'(r_p9_pp[0]) + 64'(r_p9_pp[1]) + 64'(r_p9_pp[2]);
            r_p10_pp  <= r_p9_pp;
            r_p10_v   <= r_p9_v;
            r_p10_d   <= r_p9_d;
            r_p10_deg <= r_p9_deg;

            for (int i = 0; i < 3; i++) begin
                r_p11_s[i]   <= 64'(r_p10_pp[i]) - r_p10_vv;
                r_p11_s[i+3] <= 64'(r_p10_pp[i+3]);
            end
            r_p11_v   <= r_p10_v;
            r_p11_d   <= r_p10_d;
            r_p11_deg <= r_p10_deg;

            for (int i = 0; i < 6; i++) begin
                r_p12_num[i]      <= n_smag[i] + 64'(r_p11_d >> 1);
                r_p12_side.neg[i] <= r_p11_s[i][63];
            end
            for (int i = 0; i < 3; i++) begin
                r_p12_side.v[i] <= r_p11_v[i];
            end
            r_p12_side.deg <= r_p11_deg;
            r_p12_d        <= r_p11_d;
        end
    end

    logic [5:0][DN-1:0] sd_den;
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            sd_den[i] = r_p12_d;
        end
    end

    logic                           sd_vld;
    logic [5:0][rbv_pkg::SQ_W-1:0]  sd_quo;
    rbv_pkg::t_rot_side             sd_side;

    rbv_div #(
        .LANES (6),
        .DW    (DN),
        .QW    (rbv_pkg::SQ_W),
        .SW    ($bits(rbv_pkg::t_rot_side))
    ) u_div_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p12_vld),
        .i_num   (r_p12_num),
        .i_den   (sd_den),
        .i_side  (r_p12_side),
        .o_valid (sd_vld),
        .o_quo   (sd_quo),
        .o_side  (sd_side)
    );

    // ---------------- stages 13..15: assemble, round, saturate ----------------
    logic               r_p13_vld, r_p14_vld, r_out_vld;
    logic signed [35:0] r_p13_t [9];
    logic               r_p13_deg, r_p14_deg, r_out_deg;
    logic [21:0]        r_p14_rm [9];
    logic               r_p14_neg [9];
    logic signed [CW-1:0] r_out_m [9];

    logic signed [35:0] n_q [6];
    logic signed [35:0] n_v [3];
    logic [35:0]        n_tmag [9];
    logic signed [CW-1:0] n_m [9];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            n_q[i] = sd_side.neg[i] ? -$signed({3'b0, sd_quo[i]}) : $signed({3'b0, sd_quo[i]});
        end
        // cross product components travel unsigned in the side bundle: sign-extend
        for (int i = 0; i < 3; i++) begin
            n_v[i] = 36'($signed(sd_side.v[i]));
        end
        for (int e = 0; e < 9; e++) begin
            n_tmag[e] = r_p13_t[e][35] ? 36'(-r_p13_t[e]) : 36'(r_p13_t[e]);
        end
        for (int e = 0; e < 9; e++) begin
            if (r_p14_deg) begin
                n_m[e] = (e == 0 || e == 4 || e == 8) ? rbv_pkg::ONE_Q14 : 16'sd0;
            end else if (!r_p14_neg[e]) begin
                n_m[e] = (r_p14_rm[e] > 22'd32767) ? 16'sd32767 : $signed(r_p14_rm[e][15:0]);
            end else begin
                n_m[e] = (r_p14_rm[e] > 22'd32768) ? -16'sd32768 : -$signed(r_p14_rm[e][15:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // identity + skew + squared term / (1 + c), all Q28
            r_p13_t[0] <= rbv_pkg::ONE_Q28 + n_q[0];
            r_p13_t[1] <= n_q[3] - n_v[2];
            r_p13_t[2] <= n_q[4] + n_v[1];
            r_p13_t[3] <= n_q[3] + n_v[2];
            r_p13_t[4] <= rbv_pkg::ONE_Q28 + n_q[1];
            r_p13_t[5] <= n_q[5] - n_v[0];
            r_p13_t[6] <= n_q[4] - n_v[1];
            r_p13_t[7] <= n_q[5] + n_v[0];
            r_p13_t[8] <= rbv_pkg::ONE_Q28 + n_q[2];
            r_p13_deg  <= sd_side.deg;

            for (int e = 0; e < 9; e++) begin
                r_p14_rm[e]  <= 22'((n_tmag[e] + 36'd8192) >> 14);
                r_p14_neg[e] <= r_p13_t[e][35];
            end
            r_p14_deg <= r_p13_deg;

            r_out_m   <= n_m;
            r_out_deg <= r_p14_deg;
        end
    end

    // ---------------- valid chain and flow control ----------------
    // advance everything unless a result waits on a stalled receiver
    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_p5_vld  <= 1'b0;
            r_p6_vld  <= 1'b0;
            r_p7_vld  <= 1'b0;
            r_p8_vld  <= 1'b0;
            r_p9_vld  <= 1'b0;
            r_p10_vld <= 1'b0;
            r_p11_vld <= 1'b0;
            r_p12_vld <= 1'b0;
            r_p13_vld <= 1'b0;
            r_p14_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_p1_vld  <= i_s_tvalid;
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_p4_vld  <= r_p3_vld;
            r_p5_vld  <= sq_vld;
            r_p6_vld  <= ud_vld;
            r_p7_vld  <= r_p6_vld;
            r_p8_vld  <= r_p7_vld;
            r_p9_vld  <= r_p8_vld;
            r_p10_vld <= r_p9_vld;
            r_p11_vld <= r_p10_vld;
            r_p12_vld <= r_p11_vld;
            r_p13_vld <= sd_vld;
            r_p14_vld <= r_p13_vld;
            r_out_vld <= r_p14_vld;
        end
    end

    always_comb begin
        for (int e = 0; e < 9; e++) begin
            o_m_tdata[CW*e +: CW] = r_out_m[e];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_deg;

endmodule

/* src/rbv_chk.sv */
// Port-level checker for the rotation-between-vectors block, bound to the top level.
module rbv_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_s_tready,
    input logic          o_m_tvalid,
    input logic          i_m_tready,
    input logic [143:0]  o_m_tdata,
    input logic          o_m_tuser,
    input logic          psel,
    input logic          penable,
    input logic          pwrite,
    input logic [2:0]    paddr,
    input logic [31:0]   pwdata,
    input logic [31:0]   prdata,
    input logic          pready
);

    // a degenerate transfer always carries the identity
    a_deg_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            o_m_tdata[15:0] == rbv_pkg::ONE_Q14 && o_m_tdata[31:16] == 16'd0 &&
            o_m_tdata[47:32] == 16'd0 && o_m_tdata[63:48] == 16'd0 &&
            o_m_tdata[79:64] == rbv_pkg::ONE_Q14 && o_m_tdata[95:80] == 16'd0 &&
            o_m_tdata[111:96] == 16'd0 && o_m_tdata[127:112] == 16'd0 &&
            o_m_tdata[143:128] == rbv_pkg::ONE_Q14)
        else $error("degenerate result is not the identity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // an empty output stage never blocks the input side
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with no result waiting");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && !paddr[2] |=>
            !(psel && !pwrite && !paddr[2]) || prdata == {17'd0, $past(pwdata[14:0])})
        else $error("min_denominator readback mismatch");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind rotation_between_vectors rbv_chk u_rbv_chk (.*);
